// ===== hw/rtl/rcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: shared types and constants
// Word types for both channels, the pipeline word that travels through the
// normaliser and the CORDIC cells, and the fixed-point constants.
// ----------------------------------------------------------------------------
package rcl_pkg;

    // Default values of the top-level parameters.
    localparam int COORD_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    // Field widths fixed by the channel words.
    localparam int RAW_W   = 32;
    localparam int WIDTH_W = 24;

    // Internal fixed-point widths.
    localparam int XW   = 64;               // vectoring x/y
    localparam int UW   = 58;               // rotated offset, Q33
    localparam int MW   = 61;               // normalised magnitude, top bit at 60
    localparam int PW   = UW + 1 - 33;      // rounded offset in board units
    localparam int PRW  = WIDTH_W + 32;     // width times inverse gain
    localparam int NORM_STAGES = 6;         // shifts of 32, 16, 8, 4, 2, 1

    // 1/K of the CORDIC in Q32, so that the stroke width times this is r/K in Q33.
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    // Vertex positions in the outline.
    localparam logic [1:0] VTX_END_POS   = 2'd0;
    localparam logic [1:0] VTX_START_ARC = 2'd1;
    localparam logic [1:0] VTX_START_NEG = 2'd2;
    localparam logic [1:0] VTX_END_ARC   = 2'd3;

    typedef struct packed {
        logic signed [RAW_W-1:0] start_x;
        logic signed [RAW_W-1:0] start_y;
        logic signed [RAW_W-1:0] end_x;
        logic signed [RAW_W-1:0] end_y;
        logic [WIDTH_W-1:0]      stroke_width;
    } seg_t;

    typedef struct packed {
        logic [1:0]              vertex_index;
        logic                    is_arc;
        logic signed [RAW_W-1:0] vert_x;
        logic signed [RAW_W-1:0] vert_y;
        logic signed [RAW_W-1:0] center_x;
        logic signed [RAW_W-1:0] center_y;
        logic                    last_vertex;
    } vtx_t;

    typedef struct packed {
        seg_t                 seg;
        logic                 zero;
        logic                 flip;
        logic [MW-1:0]        mag;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [UW-1:0] u;
        logic signed [UW-1:0] w;
    } pipe_t;

endpackage

// ===== hw/rtl/rcl_front.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: front end
// Registers the segment, forms the direction and the scaled radius, then
// folds the vector into the right half-plane and prepares the CORDIC word.
// ----------------------------------------------------------------------------
module rcl_front #(
    parameter int COORD_BITS = rcl_pkg::COORD_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  rcl_pkg::seg_t in_data,
    output logic          out_vld,
    output rcl_pkg::pipe_t out_data
);

    localparam int CW = COORD_BITS;

    logic                          a_vld_reg;
    rcl_pkg::seg_t                 a_seg_reg;
    logic signed [CW:0]            a_dx_reg;
    logic signed [CW:0]            a_dy_reg;
    logic [rcl_pkg::PRW-1:0]       a_prod_reg;
    logic                          a_zero_reg;

    logic signed [CW:0]            a_dx_next;
    logic signed [CW:0]            a_dy_next;
    logic [rcl_pkg::PRW-1:0]       a_prod_next;
    logic                          a_zero_next;

    logic                          b_vld_reg;
    rcl_pkg::pipe_t                b_reg;
    rcl_pkg::pipe_t                b_next;

    logic signed [rcl_pkg::XW-1:0] xd;
    logic signed [rcl_pkg::XW-1:0] yd;
    logic signed [rcl_pkg::XW-1:0] ay;
    logic [rcl_pkg::UW-1:0]        w_mag;

    // Coordinates are the low COORD_BITS bits of the zero-extended word.
    function automatic logic signed [CW-1:0] to_coord(input logic [rcl_pkg::RAW_W-1:0] raw);
        logic [63:0] r64;
        r64 = {32'd0, raw};
        return r64[CW-1:0];
    endfunction

    always_comb begin
        logic signed [CW-1:0] sxc;
        logic signed [CW-1:0] syc;
        logic signed [CW-1:0] exc;
        logic signed [CW-1:0] eyc;
        sxc = to_coord(in_data.start_x);
        syc = to_coord(in_data.start_y);
        exc = to_coord(in_data.end_x);
        eyc = to_coord(in_data.end_y);
        a_dx_next   = (CW+1)'(sxc) - (CW+1)'(exc);
        a_dy_next   = (CW+1)'(syc) - (CW+1)'(eyc);
        a_zero_next = (sxc == exc) && (syc == eyc);
        a_prod_next = rcl_pkg::PRW'(in_data.stroke_width) * rcl_pkg::PRW'(rcl_pkg::INV_GAIN_Q32);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_seg_reg  <= in_data;
            a_dx_reg   <= a_dx_next;
            a_dy_reg   <= a_dy_next;
            a_prod_reg <= a_prod_next;
            a_zero_reg <= a_zero_next;
        end
    end

    // A negative x turns the whole vector by a half turn; the offset is turned
    // back when it is rounded.
    always_comb begin
        xd    = rcl_pkg::XW'(a_dx_reg);
        yd    = rcl_pkg::XW'(a_dy_reg);
        ay    = yd[rcl_pkg::XW-1] ? -yd : yd;
        w_mag = a_zero_reg ? (rcl_pkg::UW'(a_seg_reg.stroke_width) << 32)
                           : rcl_pkg::UW'(a_prod_reg);
        b_next.seg  = a_seg_reg;
        b_next.zero = a_zero_reg;
        b_next.flip = a_dx_reg[CW];
        b_next.x    = a_dx_reg[CW] ? -xd : xd;
        b_next.y    = a_dx_reg[CW] ? -yd : yd;
        b_next.mag  = b_next.x[rcl_pkg::MW-1:0] | ay[rcl_pkg::MW-1:0];
        b_next.u    = '0;
        b_next.w    = -$signed(w_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg <= b_next;
        end
    end

    assign out_vld  = b_vld_reg;
    assign out_data = b_reg;

endmodule

// ===== hw/rtl/rcl_norm_stage.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: normaliser stage
// One step of the leading-one search: shifts the direction left by SHIFT when
// the top SHIFT bits of the magnitude are clear.
// ----------------------------------------------------------------------------
module rcl_norm_stage #(
    parameter int SHIFT = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_vld,
    input  rcl_pkg::pipe_t in_data,
    output logic           out_vld,
    output rcl_pkg::pipe_t out_data
);

    logic           vld_reg;
    rcl_pkg::pipe_t d_reg;
    rcl_pkg::pipe_t d_next;

    always_comb begin
        d_next = in_data;
        if (in_data.mag[rcl_pkg::MW-1 -: SHIFT] == '0) begin
            d_next.mag = in_data.mag << SHIFT;
            d_next.x   = in_data.x <<< SHIFT;
            d_next.y   = in_data.y <<< SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = d_reg;

endmodule

// ===== hw/rtl/rcl_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: CORDIC cell
// One vectoring step on (x, y) and the matching rotation of the offset
// (u, w), with a fixed shift of SHIFT.
// ----------------------------------------------------------------------------
module rcl_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_vld,
    input  rcl_pkg::pipe_t in_data,
    output logic           out_vld,
    output rcl_pkg::pipe_t out_data
);

    logic           vld_reg;
    rcl_pkg::pipe_t d_reg;
    rcl_pkg::pipe_t d_next;

    always_comb begin
        logic signed [rcl_pkg::XW-1:0] x;
        logic signed [rcl_pkg::XW-1:0] y;
        logic signed [rcl_pkg::UW-1:0] u;
        logic signed [rcl_pkg::UW-1:0] w;
        logic signed [rcl_pkg::XW-1:0] xs;
        logic signed [rcl_pkg::XW-1:0] ys;
        logic signed [rcl_pkg::UW-1:0] us;
        logic signed [rcl_pkg::UW-1:0] ws;
        x  = in_data.x;
        y  = in_data.y;
        u  = in_data.u;
        w  = in_data.w;
        xs = x >>> SHIFT;
        ys = y >>> SHIFT;
        us = u >>> SHIFT;
        ws = w >>> SHIFT;
        d_next = in_data;
        if (!y[rcl_pkg::XW-1]) begin
            d_next.x = x + ys;
            d_next.y = y - xs;
            d_next.u = u - ws;
            d_next.w = w + us;
        end else begin
            d_next.x = x - ys;
            d_next.y = y + xs;
            d_next.u = u + ws;
            d_next.w = w - us;
        end
        // A zero-length segment keeps its straight-down offset.
        if (in_data.zero) begin
            d_next.u = u;
            d_next.w = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = d_reg;

endmodule

// ===== hw/rtl/rcl_emit.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: vertex emitter
// Rounds the offset of one segment, then sends its four vertices, one word a
// cycle when not stalled, through a registered output stage with saturated sums.
// ----------------------------------------------------------------------------
module rcl_emit #(
    parameter int COORD_BITS = rcl_pkg::COORD_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_vld,
    input  rcl_pkg::pipe_t in_data,
    output logic           take,
    output logic           m_valid,
    input  logic           m_ready,
    output rcl_pkg::vtx_t  m_data
);

    localparam int CW = COORD_BITS;
    localparam int PW = rcl_pkg::PW;
    localparam int SW = ((CW > PW) ? CW : PW) + 1;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic                   e_vld_reg;
    logic [1:0]             cnt_reg;
    rcl_pkg::seg_t          e_seg_reg;
    logic signed [PW-1:0]   e_pdx_reg;
    logic signed [PW-1:0]   e_pdy_reg;
    logic signed [PW-1:0]   e_pdx_next;
    logic signed [PW-1:0]   e_pdy_next;

    logic                   m_vld_reg;
    rcl_pkg::vtx_t          m_data_reg;
    rcl_pkg::vtx_t          m_data_next;

    logic                   out_load;

    function automatic logic signed [CW-1:0] to_coord(input logic [rcl_pkg::RAW_W-1:0] raw);
        logic [63:0] r64;
        r64 = {32'd0, raw};
        return r64[CW-1:0];
    endfunction

    // Q33 to board units, rounding half upwards; a half-turned offset is
    // negated in the same add.
    function automatic logic signed [PW-1:0] round_q33(input logic signed [rcl_pkg::UW-1:0] v,
                                                       input logic neg);
        logic signed [rcl_pkg::UW:0] t;
        logic signed [rcl_pkg::UW:0] bias;
        bias = neg ? ((rcl_pkg::UW+1)'(1) << 32) + (rcl_pkg::UW+1)'(1)
                   : ((rcl_pkg::UW+1)'(1) << 32);
        t = (rcl_pkg::UW+1)'(neg ? ~v : v) + bias;
        return t[rcl_pkg::UW:33];
    endfunction

    function automatic logic [rcl_pkg::RAW_W-1:0] to_word(input logic signed [CW-1:0] c);
        logic signed [63:0] c64;
        c64 = 64'(c);
        return c64[rcl_pkg::RAW_W-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_sum(input logic signed [CW-1:0] base,
                                                     input logic signed [PW-1:0] pd,
                                                     input logic sub);
        logic signed [SW-1:0] pe;
        logic signed [SW-1:0] s;
        pe = SW'(pd);
        s  = SW'(base) + (sub ? ~pe : pe) + SW'(sub);
        if (s > SAT_HI) begin
            return SAT_HI[CW-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[CW-1:0];
        end
        return s[CW-1:0];
    endfunction

    assign out_load = e_vld_reg && (!m_vld_reg || m_ready);
    assign take     = !e_vld_reg || (out_load && (cnt_reg == rcl_pkg::VTX_END_ARC));

    always_comb begin
        e_pdx_next = round_q33(in_data.u, in_data.flip);
        e_pdy_next = round_q33(in_data.w, in_data.flip);
    end

    always_comb begin
        logic                 from_start;
        logic                 sub;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        from_start = 1'b0;
        sub        = 1'b0;
        case (cnt_reg)
            rcl_pkg::VTX_END_POS: begin
                from_start = 1'b0;
                sub        = 1'b0;
            end
            rcl_pkg::VTX_START_ARC: begin
                from_start = 1'b1;
                sub        = 1'b0;
            end
            rcl_pkg::VTX_START_NEG: begin
                from_start = 1'b1;
                sub        = 1'b1;
            end
            rcl_pkg::VTX_END_ARC: begin
                from_start = 1'b0;
                sub        = 1'b1;
            end
            default: begin
                from_start = 1'b0;
                sub        = 1'b0;
            end
        endcase
        bx = from_start ? to_coord(e_seg_reg.start_x) : to_coord(e_seg_reg.end_x);
        by = from_start ? to_coord(e_seg_reg.start_y) : to_coord(e_seg_reg.end_y);
        m_data_next.vertex_index = cnt_reg;
        m_data_next.is_arc       = (cnt_reg == rcl_pkg::VTX_START_ARC) ||
                                   (cnt_reg == rcl_pkg::VTX_END_ARC);
        m_data_next.vert_x       = to_word(sat_sum(bx, e_pdx_reg, sub));
        m_data_next.vert_y       = to_word(sat_sum(by, e_pdy_reg, sub));
        m_data_next.center_x     = m_data_next.is_arc ? to_word(bx) : '0;
        m_data_next.center_y     = m_data_next.is_arc ? to_word(by) : '0;
        m_data_next.last_vertex  = (cnt_reg == rcl_pkg::VTX_END_ARC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
            cnt_reg   <= rcl_pkg::VTX_END_POS;
            m_vld_reg <= 1'b0;
        end else begin
            if (take) begin
                e_vld_reg <= in_vld;
                cnt_reg   <= rcl_pkg::VTX_END_POS;
            end else if (out_load) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (out_load) begin
                m_vld_reg <= 1'b1;
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_vld) begin
            e_seg_reg <= in_data.seg;
            e_pdx_reg <= e_pdx_next;
            e_pdy_reg <= e_pdy_next;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/round_cap_line_outline_core.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline core
// Turns one line segment and its stroke width into the four vertices of its
// round-capped outline.
// ----------------------------------------------------------------------------
// Each segment word yields four vertex words: the straight side at end plus
// offset, the cap arc at start plus offset, the straight side at start minus
// offset and the cap arc at end minus offset, the arcs carrying their centres.
// The offset is half the stroke width along the perpendicular, found by a
// chain of CORDIC_STEPS cells after a six-stage normaliser, and rounded to
// whole units; every vertex coordinate saturates to the COORD_BITS range.
// In steady state a new segment is taken as the emitter loads the last of the
// four vertex words of the one before, sent one a cycle while the result port
// is ready. The first vertex passes the front-end, normaliser, CORDIC and
// emitter registers; a stall on the result port holds the whole pipeline.
module round_cap_line_outline_core #(
    parameter int COORD_BITS   = rcl_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = rcl_pkg::CORDIC_STEPS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rcl_pkg::seg_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rcl_pkg::vtx_t m_data
);

    localparam int NS = rcl_pkg::NORM_STAGES;

    logic           adv;
    logic           take;

    logic           norm_v [0:NS];
    rcl_pkg::pipe_t norm_d [0:NS];
    logic           cord_v [0:CORDIC_STEPS];
    rcl_pkg::pipe_t cord_d [0:CORDIC_STEPS];

    // Every stage moves together; it moves whenever the emitter takes the
    // word at the tail or the tail holds nothing.
    assign adv     = take || !cord_v[CORDIC_STEPS];
    assign s_ready = adv;

    rcl_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_vld  (s_valid),
        .in_data (s_data),
        .out_vld (norm_v[0]),
        .out_data(norm_d[0])
    );

    for (genvar j = 0; j < NS; j++) begin : g_norm
        rcl_norm_stage #(
            .SHIFT(1 << (NS - 1 - j))
        ) u_norm (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (norm_v[j]),
            .in_data (norm_d[j]),
            .out_vld (norm_v[j+1]),
            .out_data(norm_d[j+1])
        );
    end

    assign cord_v[0] = norm_v[NS];
    assign cord_d[0] = norm_d[NS];

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cell
        rcl_cordic_cell #(
            .SHIFT(j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (cord_v[j]),
            .in_data (cord_d[j]),
            .out_vld (cord_v[j+1]),
            .out_data(cord_d[j+1])
        );
    end

    rcl_emit #(
        .COORD_BITS(COORD_BITS)
    ) u_emit (
        .aclk   (aclk),
        .aresetn(aresetn),
        .in_vld (cord_v[CORDIC_STEPS]),
        .in_data(cord_d[CORDIC_STEPS]),
        .take   (take),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// ===== hw/rtl/rcl_port_checker.sv =====
// ----------------------------------------------------------------------------
// Round-cap line outline: port checker
// Watches the ports of the core, checks the order and shape of the vertex
// words it sends and checks that a stalled segment word is held.
// ----------------------------------------------------------------------------
module rcl_port_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input rcl_pkg::seg_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input rcl_pkg::vtx_t m_data
);

    logic [1:0] exp_idx_reg;
    logic [1:0] exp_idx_next;

    assign exp_idx_next = exp_idx_reg + 2'd1;

    // Position expected in the next vertex word sent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= rcl_pkg::VTX_END_POS;
        end else if (m_valid && m_ready) begin
            exp_idx_reg <= exp_idx_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed or dropped while stalled");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.vertex_index == exp_idx_reg)
        else $error("vertex word out of order");

    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_vertex |=> m_valid)
        else $error("gap inside the four vertex words of a segment");

    a_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_vertex == (m_data.vertex_index == rcl_pkg::VTX_END_ARC)) &&
                    (m_data.is_arc || (m_data.center_x == '0 && m_data.center_y == '0)))
        else $error("vertex flags or centre inconsistent");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("segment word changed or dropped while stalled");

endmodule

bind round_cap_line_outline_core rcl_port_checker u_rcl_port_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
